@@ rtl/max_weight_closure_min_cut_unit_assert.svh @@
// Assertion macros shared by the closure solver RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef MAX_WEIGHT_CLOSURE_MIN_CUT_UNIT_ASSERT_SVH
`define MAX_WEIGHT_CLOSURE_MIN_CUT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("closure solver assertion failed");
`define MWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("closure solver assertion failed");
`else
`define MWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/mwc_pkg.sv @@
// Package of the closure solver: default sizes, operation codes and arc kinds.
// Depends on nothing.
package mwc_pkg;
	localparam int MWC_MAX_NODES = 64;
	localparam int MWC_MAX_EDGES = 256;
	localparam int MWC_WEIGHT_BITS = 32;
	localparam int MWC_NODE_LIMIT = 64;
	localparam int MWC_END_BITS = 6;
	localparam int MWC_COUNT_BITS = 7;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_SET_WEIGHT,
		OP_ADD_EDGE,
		OP_SOLVE
	} op_t;

	typedef enum logic [1:0] {
		ARC_SRC,
		ARC_SNK,
		ARC_FWD,
		ARC_REV
	} arc_kind_t;
endpackage

@@ rtl/mwc_ram.sv @@
// Simple dual-port synchronous RAM with registered read.
// Depends on nothing.
module mwc_ram #(
	parameter int DEPTH = 64,
	parameter int AW = 6,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/max_weight_closure_min_cut_unit.sv @@
// Top level of the maximum-weight closure solver: sequencer, node, edge, parent and queue memories.
// Depends on mwc_pkg, mwc_ram and max_weight_closure_min_cut_unit_assert.svh.
//
// channel   handshake            payload
// request   req_valid/req_stall  operation, node, weight, edge_from, edge_to
// result    res_valid/res_stall  node_index, selected, objective, flow_value, last
// config    cfg_wr_en            cfg_wr_data (node count)
//
// Clear, set weight and add edge are done in the idle state as they are taken.
// Solve first sets up the node and edge capacities, then runs breadth-first searches from the source,
// each that reaches the sink followed by an augmentation along its path, then sums the objective
// and gives n results; one node and one edge memory port set the pace.
// Reset clears control state and the weight valid bits; there is no clearing pass.
// A stalled result holds in the output register; requests wait until the solve is done
// and its last result has been taken.
`include "max_weight_closure_min_cut_unit_assert.svh"
module max_weight_closure_min_cut_unit
	import mwc_pkg::*;
#(
	parameter int MAX_NODES = MWC_MAX_NODES,
	parameter int MAX_EDGES = MWC_MAX_EDGES,
	parameter int WEIGHT_BITS = MWC_WEIGHT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [MWC_COUNT_BITS-1:0]     cfg_wr_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    operation,
	input  logic [5:0]                    node,
	input  logic signed [WEIGHT_BITS-1:0] weight,
	input  logic [5:0]                    edge_from,
	input  logic [5:0]                    edge_to,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [5:0]                    node_index,
	output logic                          selected,
	output logic signed [38:0]            objective,
	output logic [37:0]                   flow_value,
	output logic                          last
);
	localparam int NODE_DEPTH = (MAX_NODES < MWC_NODE_LIMIT) ? MAX_NODES : MWC_NODE_LIMIT;
	localparam int NB = $clog2(NODE_DEPTH);
	localparam int NCW = $clog2(NODE_DEPTH + 1);
	localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int TW = $clog2(MAX_EDGES + 1);
	localparam int SCAN_MAX = (NODE_DEPTH > MAX_EDGES) ? NODE_DEPTH : MAX_EDGES;
	localparam int CW = $clog2(SCAN_MAX + 1);
	localparam int PB = (EB > NB) ? EB : NB;
	localparam int RES_W = WEIGHT_BITS + 8;
	localparam int OBJ_W = WEIGHT_BITS + 8;
	localparam int ENDS_W = 2 * MWC_END_BITS;
	localparam int NODE_DW = WEIGHT_BITS + 2 * RES_W;
	localparam int EDGE_DW = ENDS_W + 2 * RES_W;
	localparam int PAR_DW = 2 + PB;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NINIT,
		ST_EINIT,
		ST_SSTART,
		ST_SRCSCAN,
		ST_DEQ,
		ST_DEQW,
		ST_SINKCHK,
		ST_ESCAN,
		ST_W_ISSUE,
		ST_W_USE,
		ST_W_PAR,
		ST_OBJ,
		ST_EMIT
	} state_t;

	state_t                    state_q;
	logic [MWC_COUNT_BITS-1:0] nc_q;
	logic [NCW-1:0]            n_eff;
	logic [TW-1:0]             total_q;
	logic [NODE_DEPTH-1:0]     wv_q;
	logic [NODE_DEPTH-1:0]     vis_q;
	logic                      sink_vis_q;
	logic [NB-1:0]             sink_par_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             idx_s1;
	logic                      rd_v_s1;
	logic                      wv_s1;
	logic [NCW-1:0]            head_q;
	logic [NCW-1:0]            tail_q;
	logic [NB-1:0]             u_q;
	logic [RES_W-1:0]          sum_q;
	logic [RES_W-1:0]          aug_q;
	logic [RES_W-1:0]          flow_q;
	logic signed [OBJ_W-1:0]   obj_q;
	arc_kind_t                 arc_kind_q;
	logic [PB-1:0]             arc_idx_q;
	logic                      pass_q;
	logic [NCW-1:0]            e_q;
	logic                      res_valid_q;
	logic [5:0]                res_index_q;
	logic                      res_sel_q;
	logic                      res_last_q;

	logic                      req_take;
	logic                      scan_st;
	logic [CW-1:0]             scan_lim;
	logic                      scan_issue;
	logic                      scan_done;
	logic                      emit_load;
	logic                      emit_last;

	logic                      n_we;
	logic [NB-1:0]             n_waddr;
	logic [NODE_DW-1:0]        n_wdata;
	logic [NB-1:0]             n_raddr;
	logic [NODE_DW-1:0]        n_rdata;
	logic                      e_we;
	logic [EB-1:0]             e_waddr;
	logic [EDGE_DW-1:0]        e_wdata;
	logic [EB-1:0]             e_raddr;
	logic [EDGE_DW-1:0]        e_rdata;
	logic [PAR_DW-1:0]         p_rdata;
	logic [NB-1:0]             q_rdata;

	logic signed [WEIGHT_BITS-1:0] n_w;
	logic [RES_W-1:0]          n_src;
	logic [RES_W-1:0]          n_snk;
	logic [ENDS_W-1:0]         e_ends;
	logic [MWC_END_BITS-1:0]   e_a;
	logic [MWC_END_BITS-1:0]   e_b;
	logic [RES_W-1:0]          e_fwd;
	logic [RES_W-1:0]          e_rev;
	logic                      e_in_range;

	logic signed [WEIGHT_BITS-1:0] w_init;
	logic signed [RES_W-1:0]   wx;
	logic [RES_W-1:0]          pos_cap;
	logic [RES_W-1:0]          neg_cap;
	logic [RES_W-1:0]          big_cap;

	logic                      mark_en;
	logic [NB-1:0]             mark_v;
	arc_kind_t                 mark_kind;
	logic [PB-1:0]             mark_idx;

	logic [RES_W-1:0]          w_r;
	logic [NB-1:0]             w_from;

	logic                      set_ok;
	logic                      add_ok;

	always_comb begin
		if (nc_q == '0) begin
			n_eff = NCW'(1);
		end else if (nc_q > MWC_COUNT_BITS'(NODE_DEPTH)) begin
			n_eff = NCW'(NODE_DEPTH);
		end else begin
			n_eff = NCW'(nc_q);
		end
	end

	assign req_stall = (state_q != ST_IDLE) || res_valid_q;
	assign req_take = req_valid && !req_stall;
	assign set_ok = (MWC_COUNT_BITS'(node) < MWC_COUNT_BITS'(n_eff));
	assign add_ok = (total_q != TW'(MAX_EDGES));

	always_comb begin
		scan_st = state_q inside {ST_NINIT, ST_EINIT, ST_SRCSCAN, ST_ESCAN, ST_OBJ};
		if (state_q == ST_EINIT || state_q == ST_ESCAN) begin
			scan_lim = CW'(total_q);
		end else begin
			scan_lim = CW'(n_eff);
		end
		scan_issue = scan_st && (cnt_q < scan_lim);
		scan_done = scan_st && !scan_issue && !rd_v_s1;
	end

	assign n_w = n_rdata[NODE_DW-1 -: WEIGHT_BITS];
	assign n_src = n_rdata[2*RES_W-1 -: RES_W];
	assign n_snk = n_rdata[RES_W-1:0];
	assign e_ends = e_rdata[EDGE_DW-1 -: ENDS_W];
	assign e_a = e_ends[ENDS_W-1 -: MWC_END_BITS];
	assign e_b = e_ends[MWC_END_BITS-1:0];
	assign e_fwd = e_rdata[2*RES_W-1 -: RES_W];
	assign e_rev = e_rdata[RES_W-1:0];
	assign e_in_range = (MWC_COUNT_BITS'(e_a) < MWC_COUNT_BITS'(n_eff))
		&& (MWC_COUNT_BITS'(e_b) < MWC_COUNT_BITS'(n_eff));

	always_comb begin
		w_init = wv_s1 ? n_w : '0;
		wx = RES_W'(w_init);
		pos_cap = (!wx[RES_W-1] && wx != '0) ? RES_W'(wx) : '0;
		neg_cap = wx[RES_W-1] ? RES_W'(-wx) : '0;
		big_cap = sum_q + RES_W'(1);
	end

	always_comb begin
		mark_en = 1'b0;
		mark_v = '0;
		mark_kind = ARC_SRC;
		mark_idx = '0;
		if (state_q == ST_SRCSCAN && rd_v_s1 && n_src != '0
				&& !vis_q[idx_s1[NB-1:0]]) begin
			mark_en = 1'b1;
			mark_v = idx_s1[NB-1:0];
			mark_kind = ARC_SRC;
			mark_idx = PB'(idx_s1[NB-1:0]);
		end else if (state_q == ST_ESCAN && rd_v_s1 && e_in_range) begin
			if (e_a == MWC_END_BITS'(u_q) && e_fwd != '0 && !vis_q[e_b[NB-1:0]]) begin
				mark_en = 1'b1;
				mark_v = e_b[NB-1:0];
				mark_kind = ARC_FWD;
				mark_idx = PB'(idx_s1[EB-1:0]);
			end else if (e_b == MWC_END_BITS'(u_q) && e_rev != '0
					&& !vis_q[e_a[NB-1:0]]) begin
				mark_en = 1'b1;
				mark_v = e_a[NB-1:0];
				mark_kind = ARC_REV;
				mark_idx = PB'(idx_s1[EB-1:0]);
			end
		end
	end

	always_comb begin
		w_r = n_src;
		w_from = '0;
		case (arc_kind_q)
			ARC_SRC: begin
				w_r = n_src;
			end
			ARC_SNK: begin
				w_r = n_snk;
				w_from = arc_idx_q[NB-1:0];
			end
			ARC_FWD: begin
				w_r = e_fwd;
				w_from = e_a[NB-1:0];
			end
			ARC_REV: begin
				w_r = e_rev;
				w_from = e_b[NB-1:0];
			end
			default: begin
				w_r = n_src;
			end
		endcase
	end

	always_comb begin
		n_we = 1'b0;
		n_waddr = idx_s1[NB-1:0];
		n_wdata = {w_init, pos_cap, neg_cap};
		if (req_take && op_t'(operation) == OP_SET_WEIGHT && set_ok) begin
			n_we = 1'b1;
			n_waddr = node[NB-1:0];
			n_wdata = {weight, {(2*RES_W){1'b0}}};
		end else if (state_q == ST_NINIT && rd_v_s1) begin
			n_we = 1'b1;
		end else if (state_q == ST_W_USE && pass_q && arc_kind_q == ARC_SRC) begin
			n_we = 1'b1;
			n_waddr = arc_idx_q[NB-1:0];
			n_wdata = {n_w, n_src - aug_q, n_snk};
		end else if (state_q == ST_W_USE && pass_q && arc_kind_q == ARC_SNK) begin
			n_we = 1'b1;
			n_waddr = arc_idx_q[NB-1:0];
			n_wdata = {n_w, n_src, n_snk - aug_q};
		end
	end

	always_comb begin
		case (state_q)
			ST_DEQW:    n_raddr = q_rdata;
			ST_W_ISSUE: n_raddr = arc_idx_q[NB-1:0];
			default:    n_raddr = cnt_q[NB-1:0];
		endcase
	end

	always_comb begin
		e_we = 1'b0;
		e_waddr = idx_s1[EB-1:0];
		e_wdata = {e_ends, big_cap, {RES_W{1'b0}}};
		if (req_take && op_t'(operation) == OP_ADD_EDGE && add_ok) begin
			e_we = 1'b1;
			e_waddr = total_q[EB-1:0];
			e_wdata = {edge_from, edge_to, {(2*RES_W){1'b0}}};
		end else if (state_q == ST_EINIT && rd_v_s1) begin
			e_we = 1'b1;
		end else if (state_q == ST_W_USE && pass_q && arc_kind_q == ARC_FWD) begin
			e_we = 1'b1;
			e_waddr = arc_idx_q[EB-1:0];
			e_wdata = {e_ends, e_fwd - aug_q, e_rev + aug_q};
		end else if (state_q == ST_W_USE && pass_q && arc_kind_q == ARC_REV) begin
			e_we = 1'b1;
			e_waddr = arc_idx_q[EB-1:0];
			e_wdata = {e_ends, e_fwd + aug_q, e_rev - aug_q};
		end
	end

	assign e_raddr = (state_q == ST_W_ISSUE) ? arc_idx_q[EB-1:0] : cnt_q[EB-1:0];

	mwc_ram #(.DEPTH(NODE_DEPTH), .AW(NB), .DW(NODE_DW)) u_node_mem (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	mwc_ram #(.DEPTH(MAX_EDGES), .AW(EB), .DW(EDGE_DW)) u_edge_mem (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	mwc_ram #(.DEPTH(NODE_DEPTH), .AW(NB), .DW(PAR_DW)) u_parent_mem (
		.clk   (clk),
		.we    (mark_en),
		.waddr (mark_v),
		.wdata ({mark_kind, mark_idx}),
		.raddr (w_from),
		.rdata (p_rdata)
	);

	mwc_ram #(.DEPTH(NODE_DEPTH), .AW(NB), .DW(NB)) u_queue_mem (
		.clk   (clk),
		.we    (mark_en),
		.waddr (tail_q[NB-1:0]),
		.wdata (mark_v),
		.raddr (head_q[NB-1:0]),
		.rdata (q_rdata)
	);

	assign emit_load = (state_q == ST_EMIT) && (!res_valid_q || !res_stall);
	assign emit_last = (e_q == n_eff - NCW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nc_q <= MWC_COUNT_BITS'(MWC_NODE_LIMIT);
			total_q <= '0;
			wv_q <= '0;
			vis_q <= '0;
			sink_vis_q <= 1'b0;
			sink_par_q <= '0;
			cnt_q <= '0;
			idx_s1 <= '0;
			rd_v_s1 <= 1'b0;
			wv_s1 <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			u_q <= '0;
			sum_q <= '0;
			aug_q <= '0;
			flow_q <= '0;
			obj_q <= '0;
			arc_kind_q <= ARC_SRC;
			arc_idx_q <= '0;
			pass_q <= 1'b0;
			e_q <= '0;
			res_valid_q <= 1'b0;
			res_index_q <= '0;
			res_sel_q <= 1'b0;
			res_last_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				nc_q <= cfg_wr_data;
			end
			rd_v_s1 <= scan_issue;
			idx_s1 <= cnt_q;
			wv_s1 <= wv_q[cnt_q[NB-1:0]];
			if (scan_issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (mark_en) begin
				vis_q[mark_v] <= 1'b1;
				tail_q <= tail_q + NCW'(1);
			end
			if (res_valid_q && !res_stall && !emit_load) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						case (op_t'(operation))
							OP_CLEAR: begin
								wv_q <= '0;
								total_q <= '0;
							end
							OP_SET_WEIGHT: begin
								if (set_ok) begin
									wv_q[node[NB-1:0]] <= 1'b1;
								end
							end
							OP_ADD_EDGE: begin
								if (add_ok) begin
									total_q <= total_q + TW'(1);
								end
							end
							OP_SOLVE: begin
								cnt_q <= '0;
								sum_q <= '0;
								flow_q <= '0;
								state_q <= ST_NINIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_NINIT: begin
					if (rd_v_s1) begin
						sum_q <= sum_q + pos_cap + neg_cap;
					end
					if (scan_done) begin
						cnt_q <= '0;
						state_q <= ST_EINIT;
					end
				end
				ST_EINIT: begin
					if (scan_done) begin
						state_q <= ST_SSTART;
					end
				end
				ST_SSTART: begin
					vis_q <= '0;
					sink_vis_q <= 1'b0;
					head_q <= '0;
					tail_q <= '0;
					cnt_q <= '0;
					state_q <= ST_SRCSCAN;
				end
				ST_SRCSCAN: begin
					if (scan_done) begin
						state_q <= ST_DEQ;
					end
				end
				ST_DEQ: begin
					if (sink_vis_q) begin
						arc_kind_q <= ARC_SNK;
						arc_idx_q <= PB'(sink_par_q);
						pass_q <= 1'b0;
						aug_q <= '1;
						state_q <= ST_W_ISSUE;
					end else if (head_q == tail_q) begin
						cnt_q <= '0;
						obj_q <= '0;
						state_q <= ST_OBJ;
					end else begin
						head_q <= head_q + NCW'(1);
						state_q <= ST_DEQW;
					end
				end
				ST_DEQW: begin
					u_q <= q_rdata;
					state_q <= ST_SINKCHK;
				end
				ST_SINKCHK: begin
					if (n_snk != '0 && !sink_vis_q) begin
						sink_vis_q <= 1'b1;
						sink_par_q <= u_q;
						state_q <= ST_DEQ;
					end else begin
						cnt_q <= '0;
						state_q <= ST_ESCAN;
					end
				end
				ST_ESCAN: begin
					if (scan_done) begin
						state_q <= ST_DEQ;
					end
				end
				ST_W_ISSUE: begin
					state_q <= ST_W_USE;
				end
				ST_W_USE: begin
					if (!pass_q && w_r < aug_q) begin
						aug_q <= w_r;
					end
					if (arc_kind_q == ARC_SRC) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							arc_kind_q <= ARC_SNK;
							arc_idx_q <= PB'(sink_par_q);
							state_q <= ST_W_ISSUE;
						end else begin
							flow_q <= flow_q + aug_q;
							state_q <= ST_SSTART;
						end
					end else begin
						state_q <= ST_W_PAR;
					end
				end
				ST_W_PAR: begin
					arc_kind_q <= arc_kind_t'(p_rdata[PAR_DW-1 -: 2]);
					arc_idx_q <= p_rdata[PB-1:0];
					state_q <= ST_W_ISSUE;
				end
				ST_OBJ: begin
					if (rd_v_s1 && vis_q[idx_s1[NB-1:0]]) begin
						obj_q <= obj_q + OBJ_W'(n_w);
					end
					if (scan_done) begin
						e_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						res_valid_q <= 1'b1;
						res_index_q <= 6'(e_q);
						res_sel_q <= vis_q[e_q[NB-1:0]];
						res_last_q <= emit_last;
						e_q <= e_q + NCW'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign node_index = res_index_q;
	assign selected = res_sel_q;
	assign objective = 39'(obj_q);
	assign flow_value = 38'(flow_q);
	assign last = res_last_q;

	`MWC_ASSERT_IMP(a_queue_order, clk, arst_n, 1'b1, head_q <= tail_q)
	`MWC_ASSERT_IMP(a_queue_bound, clk, arst_n, state_q == ST_ESCAN, tail_q <= n_eff)
	`MWC_ASSERT_IMP(a_emit_origin, clk, arst_n, $rose(res_valid_q), $past(state_q) == ST_EMIT)
	`MWC_ASSERT_NXT(a_emit_end, clk, arst_n, emit_load && emit_last, state_q == ST_IDLE)
	`MWC_ASSERT_IMP(a_aug_positive, clk, arst_n,
		state_q == ST_W_USE && pass_q && arc_kind_q == ARC_SRC, aug_q != '0)
endmodule
